// ===== rtl/ahlz_pkg.sv =====
// Shared types, codes and constant tables for the adaptive Huffman LZ decompressor.
package ahlz_pkg;

    localparam int WW = 16;
    localparam int SHIFT_W = 16;
    localparam int BITS_W = 5;
    localparam int EXT_W = 14;
    localparam int GOT_W = 4;
    localparam int RANGE_W = 3;
    localparam int ALU_W = 17;
    localparam int ROOT_NODE = 1;
    localparam int WEIGHT_LIMIT = 2000;
    localparam int SYM_TERMINATE = 256;
    localparam int FIRST_COPY = 257;
    localparam int LAST_RANGE = 5;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_PUSH  = 2'd1,
        OP_PULL  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STAT_BYTE = 2'd0,
        STAT_NEED = 2'd1,
        STAT_END  = 2'd2,
        STAT_ACK  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_WALK  = 2'd0,
        PH_EXTRA = 2'd1,
        PH_COPY  = 2'd2,
        PH_END   = 2'd3
    } phase_t;

    typedef enum logic {
        RET_MAIN = 1'b0,
        RET_SWAP = 1'b1
    } ret_t;

    typedef enum logic [5:0] {
        S_CLEAR, S_IDLE, S_WALK, S_WALK_NEXT, S_UPD0, S_UPD1, S_SIB,
        S_RF0, S_RF1, S_RF2, S_RF3, S_RF4, S_RE0, S_RE1, S_HALF0, S_HALF1,
        S_L0, S_L1, S_L2, S_L3, S_L4, S_SW0, S_SW1, S_SW2, S_SW3,
        S_LN0, S_LN1, S_LN2, S_SYM, S_RANGE, S_EXTRA, S_DMOD, S_SRC,
        S_COPY0, S_COPY1, S_RESP
    } state_t;

    function automatic logic [GOT_W-1:0] range_bits(input logic [RANGE_W-1:0] idx);
        logic [GOT_W-1:0] r;
        case (idx)
            3'd0: r = 4'd4;
            3'd1: r = 4'd6;
            3'd2: r = 4'd8;
            3'd3: r = 4'd10;
            3'd4: r = 4'd12;
            default: r = 4'd14;
        endcase
        return r;
    endfunction

    function automatic logic [12:0] range_base(input logic [RANGE_W-1:0] idx);
        logic [12:0] r;
        case (idx)
            3'd0: r = 13'd0;
            3'd1: r = 13'd16;
            3'd2: r = 13'd80;
            3'd3: r = 13'd336;
            3'd4: r = 13'd1360;
            default: r = 13'd5456;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/ahlz_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module ahlz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/adaptive_huffman_lz_decompressor.sv =====
// Top level of the adaptive Huffman LZ decompressor with its sequencer and tree memories.
//
// One request channel (in_valid, in_stall, op, data_word) and one result channel
// (out_valid, out_stall, out_byte, status, is_last). Every request gives exactly one result.
// A start request rebuilds the tree in a sweep over every node and answers 3.
// A push request loads a 16-bit word when the bit reader is empty and answers 3.
// A pull request decodes until one byte is ready (status 0), the bit reader runs dry
// (status 1), or the terminate code is seen (status 2 with is_last).
// A pull walks the tree one bit at a time (S_WALK, S_WALK_NEXT), then updates the weights:
// a weight refresh per level (S_RF0 to S_RF4) and a swap check per level (S_L0 to S_L4,
// S_LN0 to S_LN2), plus the swap steps S_SW0 to S_SW3 and a second refresh where two nodes
// trade places, all through single-port-per-cycle tree memories.
// When the root weight reaches 2000 all weights are halved, one node after another.
// After reset the same tree sweep runs before the first request.
// The block takes one request at a time; in_stall is low only while it waits for one.
// A finished result sits in the output register, so the next request is accepted while
// the receiver stalls; that request's result waits until the register is free.
module adaptive_huffman_lz_decompressor
    import ahlz_pkg::*;
#(
    parameter int HISTORY_DEPTH = 21644,
    parameter int TREE_NODES = 3549,
    parameter int COPY_MIN = 3,
    parameter int CODES_PER_RANGE = 253
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [15:0] data_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic [1:0]  status,
    output logic        is_last
);

    localparam int INNER = (TREE_NODES - 1) / 2;
    localparam int LEAF_BASE = INNER + 1;
    localparam int LEAVES = TREE_NODES - INNER;
    localparam int NW = $clog2(TREE_NODES + 1);
    localparam int IW = $clog2(INNER + 1);
    localparam int HW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(LEAVES + COPY_MIN + 1);
    localparam logic [NW-1:0] INNER_N = NW'(INNER);
    localparam logic [NW-1:0] LEAF_N = NW'(LEAF_BASE);
    localparam logic [NW-1:0] LAST_N = NW'(TREE_NODES);
    localparam logic [NW-1:0] ROOT_N = NW'(ROOT_NODE);
    localparam logic [HW-1:0] HLAST = HW'(HISTORY_DEPTH - 1);
    localparam logic [ALU_W-1:0] H_A = ALU_W'(HISTORY_DEPTH);
    localparam logic [ALU_W-1:0] CPR_A = ALU_W'(CODES_PER_RANGE);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    ret_t ret_reg, ret_next;
    logic clr_resp_reg, clr_resp_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic [BITS_W-1:0] bits_reg, bits_next;
    logic [HW-1:0] wpos_reg, wpos_next;
    logic [HW-1:0] csrc_reg, csrc_next;
    logic [CW-1:0] crem_reg, crem_next;
    logic [NW-1:0] walk_reg, walk_next;
    logic bit_reg, bit_next;
    logic [EXT_W-1:0] ext_reg, ext_next;
    logic [GOT_W-1:0] got_reg, got_next;
    logic [GOT_W-1:0] need_reg, need_next;
    logic [RANGE_W-1:0] range_reg, range_next;
    logic [NW-1:0] a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [NW-1:0] up_reg, up_next, top_reg, top_next, p_reg, p_next;
    logic [NW-1:0] fa_reg, fa_next, fb_reg, fb_next;
    logic [NW-1:0] sym_reg, sym_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic [WW-1:0] wa_reg, wa_next;
    logic upleft_reg, upleft_next;
    logic [ALU_W-1:0] dist_reg, dist_next;
    logic [7:0] resp_byte_reg, resp_byte_next;
    status_t resp_stat_reg, resp_stat_next;
    logic out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    status_t out_stat_reg, out_stat_next;
    logic out_last_reg, out_last_next;

    logic par_we, wgt_we, lft_we, rgt_we, his_we;
    logic [NW-1:0] par_waddr, par_raddr, par_wdata, par_rdata;
    logic [NW-1:0] wgt_waddr, wgt_raddr;
    logic [WW-1:0] wgt_wdata, wgt_rdata;
    logic [IW-1:0] lft_waddr, lft_raddr, rgt_waddr, rgt_raddr;
    logic [NW-1:0] lft_wdata, lft_rdata, rgt_wdata, rgt_rdata;
    logic [HW-1:0] his_waddr, his_raddr;
    logic [7:0] his_wdata, his_rdata;

    logic [ALU_W-1:0] alu_x, alu_y, alu_diff;
    logic alu_ge;
    logic [NW-1:0] child;
    logic [HW-1:0] wpos_inc, csrc_inc;

    ahlz_ram #(.WIDTH(NW), .DEPTH(TREE_NODES + 1)) u_par (
        .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
        .raddr(par_raddr), .rdata(par_rdata)
    );
    ahlz_ram #(.WIDTH(WW), .DEPTH(TREE_NODES + 1)) u_wgt (
        .clk(clk), .we(wgt_we), .waddr(wgt_waddr), .wdata(wgt_wdata),
        .raddr(wgt_raddr), .rdata(wgt_rdata)
    );
    ahlz_ram #(.WIDTH(NW), .DEPTH(INNER + 1)) u_lft (
        .clk(clk), .we(lft_we), .waddr(lft_waddr), .wdata(lft_wdata),
        .raddr(lft_raddr), .rdata(lft_rdata)
    );
    ahlz_ram #(.WIDTH(NW), .DEPTH(INNER + 1)) u_rgt (
        .clk(clk), .we(rgt_we), .waddr(rgt_waddr), .wdata(rgt_wdata),
        .raddr(rgt_raddr), .rdata(rgt_rdata)
    );
    ahlz_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_his (
        .clk(clk), .we(his_we), .waddr(his_waddr), .wdata(his_wdata),
        .raddr(his_raddr), .rdata(his_rdata)
    );

    // The shared compare and subtract unit serves the range split and both ring modulos.
    assign alu_ge = (alu_x >= alu_y);
    assign alu_diff = alu_x - alu_y;
    assign child = bit_reg ? rgt_rdata : lft_rdata;
    assign wpos_inc = (wpos_reg == HLAST) ? '0 : wpos_reg + HW'(1);
    assign csrc_inc = (csrc_reg == HLAST) ? '0 : csrc_reg + HW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            phase_reg <= PH_WALK;
            ret_reg <= RET_MAIN;
            clr_resp_reg <= 1'b0;
            shift_reg <= '0;
            bits_reg <= '0;
            wpos_reg <= '0;
            csrc_reg <= '0;
            crem_reg <= '0;
            walk_reg <= ROOT_N;
            got_reg <= '0;
            need_reg <= '0;
            range_reg <= '0;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            ret_reg <= ret_next;
            clr_resp_reg <= clr_resp_next;
            shift_reg <= shift_next;
            bits_reg <= bits_next;
            wpos_reg <= wpos_next;
            csrc_reg <= csrc_next;
            crem_reg <= crem_next;
            walk_reg <= walk_next;
            got_reg <= got_next;
            need_reg <= need_next;
            range_reg <= range_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
        ext_reg <= ext_next;
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        up_reg <= up_next;
        top_reg <= top_next;
        p_reg <= p_next;
        fa_reg <= fa_next;
        fb_reg <= fb_next;
        sym_reg <= sym_next;
        wa_reg <= wa_next;
        upleft_reg <= upleft_next;
        dist_reg <= dist_next;
        resp_byte_reg <= resp_byte_next;
        resp_stat_reg <= resp_stat_next;
        out_byte_reg <= out_byte_next;
        out_stat_reg <= out_stat_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        ret_next = ret_reg;
        clr_resp_next = clr_resp_reg;
        shift_next = shift_reg;
        bits_next = bits_reg;
        wpos_next = wpos_reg;
        csrc_next = csrc_reg;
        crem_next = crem_reg;
        walk_next = walk_reg;
        bit_next = bit_reg;
        ext_next = ext_reg;
        got_next = got_reg;
        need_next = need_reg;
        range_next = range_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        up_next = up_reg;
        top_next = top_reg;
        p_next = p_reg;
        fa_next = fa_reg;
        fb_next = fb_reg;
        sym_next = sym_reg;
        cnt_next = cnt_reg;
        wa_next = wa_reg;
        upleft_next = upleft_reg;
        dist_next = dist_reg;
        resp_byte_next = resp_byte_reg;
        resp_stat_next = resp_stat_reg;
        out_byte_next = out_byte_reg;
        out_stat_next = out_stat_reg;
        out_last_next = out_last_reg;
        out_valid_next = out_valid_reg && out_stall;

        par_we = 1'b0;
        par_waddr = '0;
        par_wdata = '0;
        par_raddr = '0;
        wgt_we = 1'b0;
        wgt_waddr = '0;
        wgt_wdata = '0;
        wgt_raddr = '0;
        lft_we = 1'b0;
        lft_waddr = '0;
        lft_wdata = '0;
        lft_raddr = '0;
        rgt_we = 1'b0;
        rgt_waddr = '0;
        rgt_wdata = '0;
        rgt_raddr = '0;
        his_we = 1'b0;
        his_waddr = wpos_reg;
        his_wdata = '0;
        his_raddr = csrc_reg;
        alu_x = dist_reg;
        alu_y = H_A;

        case (state_reg)
            S_CLEAR:
            begin
                par_we = 1'b1;
                par_waddr = cnt_reg;
                par_wdata = cnt_reg >> 1;
                wgt_we = 1'b1;
                wgt_waddr = cnt_reg;
                wgt_wdata = WW'(1);
                if (cnt_reg <= INNER_N)
                begin
                    lft_we = 1'b1;
                    lft_waddr = cnt_reg[IW-1:0];
                    lft_wdata = {cnt_reg[NW-2:0], 1'b0};
                    rgt_we = 1'b1;
                    rgt_waddr = cnt_reg[IW-1:0];
                    rgt_wdata = {cnt_reg[NW-2:0], 1'b1};
                end
                cnt_next = cnt_reg + NW'(1);
                if (cnt_reg == LAST_N)
                begin
                    resp_stat_next = STAT_ACK;
                    resp_byte_next = '0;
                    state_next = clr_resp_reg ? S_RESP : S_IDLE;
                end
            end
            S_IDLE:
            begin
                resp_byte_next = '0;
                resp_stat_next = STAT_ACK;
                if (in_valid)
                begin
                    state_next = S_RESP;
                    case (op)
                        OP_START:
                        begin
                            shift_next = '0;
                            bits_next = '0;
                            wpos_next = '0;
                            csrc_next = '0;
                            crem_next = '0;
                            phase_next = PH_WALK;
                            walk_next = ROOT_N;
                            got_next = '0;
                            need_next = '0;
                            range_next = '0;
                            cnt_next = '0;
                            clr_resp_next = 1'b1;
                            state_next = S_CLEAR;
                        end
                        OP_PUSH:
                        begin
                            if (bits_reg == '0)
                            begin
                                shift_next = data_word;
                                bits_next = BITS_W'(16);
                            end
                        end
                        OP_PULL:
                        begin
                            case (phase_reg)
                                PH_END: resp_stat_next = STAT_END;
                                PH_COPY: state_next = S_COPY0;
                                PH_EXTRA: state_next = S_EXTRA;
                                default: state_next = S_WALK;
                            endcase
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (walk_reg > INNER_N)
                begin
                    a_next = walk_reg;
                    sym_next = walk_reg - LEAF_N;
                    walk_next = ROOT_N;
                    state_next = S_UPD0;
                end
                else if (bits_reg == '0)
                begin
                    resp_stat_next = STAT_NEED;
                    state_next = S_RESP;
                end
                else
                begin
                    bit_next = shift_reg[SHIFT_W-1];
                    shift_next = shift_reg << 1;
                    bits_next = bits_reg - BITS_W'(1);
                    lft_raddr = walk_reg[IW-1:0];
                    rgt_raddr = walk_reg[IW-1:0];
                    state_next = S_WALK_NEXT;
                end
            end
            S_WALK_NEXT:
            begin
                walk_next = (child == '0) ? ROOT_N : child;
                state_next = S_WALK;
            end
            S_UPD0:
            begin
                wgt_raddr = a_reg;
                par_raddr = a_reg;
                state_next = S_UPD1;
            end
            S_UPD1:
            begin
                wgt_we = 1'b1;
                wgt_waddr = a_reg;
                wgt_wdata = wgt_rdata + WW'(1);
                up_next = par_rdata;
                lft_raddr = par_rdata[IW-1:0];
                rgt_raddr = par_rdata[IW-1:0];
                state_next = (par_rdata == ROOT_N) ? S_SYM : S_SIB;
            end
            S_SIB:
            begin
                fa_next = a_reg;
                fb_next = (lft_rdata == a_reg) ? rgt_rdata : lft_rdata;
                ret_next = RET_MAIN;
                state_next = S_RF0;
            end
            S_RF0:
            begin
                wgt_raddr = fa_reg;
                par_raddr = fa_reg;
                state_next = S_RF1;
            end
            S_RF1:
            begin
                wa_next = wgt_rdata;
                p_next = par_rdata;
                wgt_raddr = fb_reg;
                state_next = S_RF2;
            end
            S_RF2:
            begin
                wgt_we = 1'b1;
                wgt_waddr = p_reg;
                wgt_wdata = wa_reg + wgt_rdata;
                fa_next = p_reg;
                par_raddr = p_reg;
                state_next = (p_reg == ROOT_N || p_reg == '0) ? S_RE0 : S_RF3;
            end
            S_RF3:
            begin
                lft_raddr = par_rdata[IW-1:0];
                rgt_raddr = par_rdata[IW-1:0];
                state_next = S_RF4;
            end
            S_RF4:
            begin
                fb_next = (lft_rdata == fa_reg) ? rgt_rdata : lft_rdata;
                state_next = S_RF0;
            end
            S_RE0:
            begin
                wgt_raddr = ROOT_N;
                state_next = S_RE1;
            end
            S_RE1:
            begin
                if (wgt_rdata == WW'(WEIGHT_LIMIT))
                begin
                    cnt_next = ROOT_N;
                    state_next = S_HALF0;
                end
                else
                begin
                    state_next = (ret_reg == RET_SWAP) ? S_SW3 : S_L0;
                end
            end
            S_HALF0:
            begin
                wgt_raddr = cnt_reg;
                state_next = S_HALF1;
            end
            S_HALF1:
            begin
                wgt_we = 1'b1;
                wgt_waddr = cnt_reg;
                wgt_wdata = wgt_rdata >> 1;
                cnt_next = cnt_reg + NW'(1);
                if (cnt_reg == LAST_N)
                begin
                    state_next = (ret_reg == RET_SWAP) ? S_SW3 : S_L0;
                end
                else
                begin
                    state_next = S_HALF0;
                end
            end
            S_L0:
            begin
                par_raddr = up_reg;
                state_next = S_L1;
            end
            S_L1:
            begin
                top_next = par_rdata;
                lft_raddr = par_rdata[IW-1:0];
                rgt_raddr = par_rdata[IW-1:0];
                state_next = S_L2;
            end
            S_L2:
            begin
                upleft_next = (lft_rdata == up_reg);
                b_next = (lft_rdata == up_reg) ? rgt_rdata : lft_rdata;
                wgt_raddr = a_reg;
                state_next = S_L3;
            end
            S_L3:
            begin
                wa_next = wgt_rdata;
                wgt_raddr = b_reg;
                state_next = S_L4;
            end
            S_L4:
            begin
                state_next = (wa_reg > wgt_rdata) ? S_SW0 : S_LN0;
            end
            S_SW0:
            begin
                if (upleft_reg)
                begin
                    rgt_we = 1'b1;
                    rgt_waddr = top_reg[IW-1:0];
                    rgt_wdata = a_reg;
                end
                else
                begin
                    lft_we = 1'b1;
                    lft_waddr = top_reg[IW-1:0];
                    lft_wdata = a_reg;
                end
                lft_raddr = up_reg[IW-1:0];
                rgt_raddr = up_reg[IW-1:0];
                state_next = S_SW1;
            end
            S_SW1:
            begin
                if (lft_rdata == a_reg)
                begin
                    lft_we = 1'b1;
                    lft_waddr = up_reg[IW-1:0];
                    lft_wdata = b_reg;
                    c_next = rgt_rdata;
                end
                else
                begin
                    rgt_we = 1'b1;
                    rgt_waddr = up_reg[IW-1:0];
                    rgt_wdata = b_reg;
                    c_next = lft_rdata;
                end
                par_we = 1'b1;
                par_waddr = b_reg;
                par_wdata = up_reg;
                state_next = S_SW2;
            end
            S_SW2:
            begin
                par_we = 1'b1;
                par_waddr = a_reg;
                par_wdata = top_reg;
                fa_next = b_reg;
                fb_next = c_reg;
                ret_next = RET_SWAP;
                state_next = S_RF0;
            end
            S_SW3:
            begin
                a_next = b_reg;
                state_next = S_LN0;
            end
            S_LN0:
            begin
                par_raddr = a_reg;
                state_next = S_LN1;
            end
            S_LN1:
            begin
                a_next = par_rdata;
                par_raddr = par_rdata;
                state_next = S_LN2;
            end
            S_LN2:
            begin
                up_next = par_rdata;
                state_next = (par_rdata != ROOT_N && par_rdata != '0) ? S_L0 : S_SYM;
            end
            S_SYM:
            begin
                if (sym_reg < NW'(SYM_TERMINATE))
                begin
                    his_we = 1'b1;
                    his_wdata = sym_reg[7:0];
                    wpos_next = wpos_inc;
                    resp_byte_next = sym_reg[7:0];
                    resp_stat_next = STAT_BYTE;
                    state_next = S_RESP;
                end
                else if (sym_reg == NW'(SYM_TERMINATE))
                begin
                    phase_next = PH_END;
                    resp_stat_next = STAT_END;
                    state_next = S_RESP;
                end
                else
                begin
                    dist_next = ALU_W'(sym_reg - NW'(FIRST_COPY));
                    range_next = '0;
                    state_next = S_RANGE;
                end
            end
            S_RANGE:
            begin
                alu_x = dist_reg;
                alu_y = CPR_A;
                if (range_reg != RANGE_W'(LAST_RANGE) && alu_ge)
                begin
                    dist_next = alu_diff;
                    range_next = range_reg + RANGE_W'(1);
                end
                else
                begin
                    crem_next = CW'(dist_reg) + CW'(COPY_MIN);
                    need_next = range_bits(range_reg);
                    got_next = '0;
                    ext_next = '0;
                    phase_next = PH_EXTRA;
                    state_next = S_EXTRA;
                end
            end
            S_EXTRA:
            begin
                if (got_reg < need_reg)
                begin
                    if (bits_reg == '0)
                    begin
                        resp_stat_next = STAT_NEED;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        ext_next = ext_reg | (EXT_W'(shift_reg[SHIFT_W-1]) << got_reg);
                        got_next = got_reg + GOT_W'(1);
                        shift_next = shift_reg << 1;
                        bits_next = bits_reg - BITS_W'(1);
                    end
                end
                else
                begin
                    dist_next = ALU_W'(ext_reg) + ALU_W'(crem_reg) + ALU_W'(range_base(range_reg));
                    state_next = S_DMOD;
                end
            end
            S_DMOD:
            begin
                alu_x = dist_reg;
                alu_y = H_A;
                if (alu_ge)
                begin
                    dist_next = alu_diff;
                end
                else
                begin
                    state_next = S_SRC;
                end
            end
            S_SRC:
            begin
                alu_x = ALU_W'(wpos_reg);
                alu_y = dist_reg;
                if (alu_ge)
                begin
                    csrc_next = alu_diff[HW-1:0];
                end
                else
                begin
                    csrc_next = HW'(ALU_W'(wpos_reg) + H_A - dist_reg);
                end
                phase_next = PH_COPY;
                state_next = S_COPY0;
            end
            S_COPY0:
            begin
                his_raddr = csrc_reg;
                state_next = S_COPY1;
            end
            S_COPY1:
            begin
                his_we = 1'b1;
                his_wdata = his_rdata;
                wpos_next = wpos_inc;
                csrc_next = csrc_inc;
                crem_next = crem_reg - CW'(1);
                if (crem_reg == CW'(1))
                begin
                    phase_next = PH_WALK;
                end
                resp_byte_next = his_rdata;
                resp_stat_next = STAT_BYTE;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next = (resp_stat_reg == STAT_BYTE) ? resp_byte_reg : '0;
                    out_stat_next = resp_stat_reg;
                    out_last_next = (resp_stat_reg == STAT_END);
                    clr_resp_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_byte = out_byte_reg;
    assign status = out_stat_reg;
    assign is_last = out_last_reg;

    a_last_matches_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_last == (status == STAT_END)))
        else $error("is_last disagrees with the result status");

    a_copy_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_COPY) |-> (crem_reg != '0))
        else $error("copy phase entered with no bytes left to copy");

    a_extra_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_EXTRA) |-> (got_reg <= need_reg))
        else $error("more distance bits gathered than the range needs");

    a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bits_reg <= BITS_W'(16))
        else $error("bit reader counts more bits than one word holds");

    a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == S_RESP))
        else $error("a result appeared outside the response step");

endmodule

// ===== test/adaptive_huffman_lz_decompressor_test.sv =====
// Testbench for the adaptive Huffman LZ decompressor: encoded block stimulus and response check.
module adaptive_huffman_lz_decompressor_test;
    import ahlz_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_DEPTH = 21644;
    localparam int NODES = 3549;
    localparam int INNER_N = 1774;
    localparam int LEAF_FIRST = 1775;
    localparam int COPY_LEN_MIN = 3;
    localparam int CODES_RANGE = 253;
    localparam int WRITE_CAP = 19000;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam logic [1:0] OP_IGNORED = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] word;
    } request_t;

    typedef struct {
        logic [7:0] byte_val;
        status_t    stat;
        logic       last;
    } response_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = 2'd0;
    logic [15:0] data_word = 16'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic        is_last;

    request_t  requests[$];
    response_t responses[$];
    int errors = 0;
    int bytes_checked = 0;
    int results_checked = 0;
    int blocks = 0;
    int idle_cycles = 0;
    int in_gap = 0;
    int stall_left = 0;

    // Two copies of the tree: index 0 follows the decoder, index 1 the encoder.
    logic [15:0] node_up[2][0:NODES];
    logic [15:0] node_lo[2][0:INNER_N];
    logic [15:0] node_hi[2][0:INNER_N];
    logic [15:0] node_wt[2][0:NODES];

    logic [7:0]  hist[0:HIST_DEPTH-1];
    logic [15:0] sreg;
    int bits_left, wpos, csrc, crem, walk, ext_val, ext_got, ext_need, crange;
    phase_t phase;

    bit code_bits[$];
    int plan_sym[$];
    int plan_extra[$];
    int enc_written, syms_left;
    bit term_sent;

    adaptive_huffman_lz_decompressor i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .data_word(data_word), .out_valid(out_valid), .out_stall(out_stall),
        .out_byte(out_byte), .status(status), .is_last(is_last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int extra_bits(int idx);
        return 4 + 2 * idx;
    endfunction

    function automatic int dist_base(int idx);
        case (idx)
            0: return 0;
            1: return 16;
            2: return 80;
            3: return 336;
            4: return 1360;
            default: return 5456;
        endcase
    endfunction

    function automatic int up_of(int k, int n);
        return (n <= NODES) ? int'(node_up[k][n]) : 0;
    endfunction

    function automatic int lo_of(int k, int n);
        return (n <= INNER_N) ? int'(node_lo[k][n]) : 0;
    endfunction

    function automatic int hi_of(int k, int n);
        return (n <= INNER_N) ? int'(node_hi[k][n]) : 0;
    endfunction

    function automatic int wt_of(int k, int n);
        return (n <= NODES) ? int'(node_wt[k][n]) : 0;
    endfunction

    function automatic void set_wt(int k, int n, int v);
        if (n <= NODES) node_wt[k][n] = v[15:0];
    endfunction

    function automatic void set_up(int k, int n, int v);
        if (n <= NODES) node_up[k][n] = v[15:0];
    endfunction

    function automatic void set_lo(int k, int n, int v);
        if (n <= INNER_N) node_lo[k][n] = v[15:0];
    endfunction

    function automatic void set_hi(int k, int n, int v);
        if (n <= INNER_N) node_hi[k][n] = v[15:0];
    endfunction

    function automatic int sibling_of(int k, int n);
        int p;
        p = up_of(k, n);
        return (lo_of(k, p) == n) ? hi_of(k, p) : lo_of(k, p);
    endfunction

    function automatic void tree_reset(int k);
        for (int i = 0; i <= NODES; i++)
        begin
            node_up[k][i] = 16'(i / 2);
            node_wt[k][i] = 16'd1;
        end
        for (int i = 0; i <= INNER_N; i++)
        begin
            node_lo[k][i] = 16'(2 * i);
            node_hi[k][i] = 16'(2 * i + 1);
        end
    endfunction

    function automatic void refresh_weights(int k, int a, int b);
        do
        begin
            set_wt(k, up_of(k, a), wt_of(k, a) + wt_of(k, b));
            a = up_of(k, a);
            if (a != ROOT_NODE) b = sibling_of(k, a);
        end while (a != ROOT_NODE && a != 0);
        if (wt_of(k, ROOT_NODE) == WEIGHT_LIMIT)
            for (int i = 1; i <= NODES; i++)
                node_wt[k][i] = node_wt[k][i] >> 1;
    endfunction

    function automatic void tree_update(int k, int sym);
        int a, b, c, up, top;
        a = sym + LEAF_FIRST;
        set_wt(k, a, wt_of(k, a) + 1);
        if (up_of(k, a) == ROOT_NODE) return;
        up = up_of(k, a);
        refresh_weights(k, a, sibling_of(k, a));
        do
        begin
            top = up_of(k, up);
            b = (lo_of(k, top) == up) ? hi_of(k, top) : lo_of(k, top);
            if (wt_of(k, a) > wt_of(k, b))
            begin
                if (lo_of(k, top) == up) set_hi(k, top, a);
                else set_lo(k, top, a);
                if (lo_of(k, up) == a)
                begin
                    set_lo(k, up, b);
                    c = hi_of(k, up);
                end
                else
                begin
                    set_hi(k, up, b);
                    c = lo_of(k, up);
                end
                set_up(k, b, up);
                set_up(k, a, top);
                refresh_weights(k, b, c);
                a = b;
            end
            a = up_of(k, a);
            up = up_of(k, a);
        end while (up != ROOT_NODE && up != 0);
    endfunction

    function automatic void decoder_reset();
        tree_reset(0);
        for (int i = 0; i < HIST_DEPTH; i++) hist[i] = 8'd0;
        sreg = 16'd0;
        bits_left = 0;
        wpos = 0;
        csrc = 0;
        crem = 0;
        phase = PH_WALK;
        walk = ROOT_NODE;
        ext_val = 0;
        ext_got = 0;
        ext_need = 0;
        crange = 0;
    endfunction

    function automatic int take_bit();
        int b;
        b = sreg[15];
        sreg = {sreg[14:0], 1'b0};
        bits_left--;
        return b;
    endfunction

    task automatic decode_pull(output logic [7:0] b, output status_t st);
        bit done;
        int sym, t, idx, offset;
        done = 0;
        b = 8'd0;
        st = STAT_ACK;
        while (!done)
        begin
            case (phase)
                PH_END:
                begin
                    st = STAT_END;
                    done = 1;
                end
                PH_COPY:
                begin
                    b = hist[csrc];
                    hist[wpos] = b;
                    wpos = (wpos + 1) % HIST_DEPTH;
                    csrc = (csrc + 1) % HIST_DEPTH;
                    crem--;
                    if (crem == 0) phase = PH_WALK;
                    st = STAT_BYTE;
                    done = 1;
                end
                PH_EXTRA:
                begin
                    while (ext_got < ext_need && bits_left > 0)
                    begin
                        ext_val = ext_val | (take_bit() << ext_got);
                        ext_got++;
                    end
                    if (ext_got < ext_need)
                    begin
                        st = STAT_NEED;
                        done = 1;
                    end
                    else
                    begin
                        offset = (ext_val + crem + dist_base(crange)) % HIST_DEPTH;
                        csrc = (wpos + HIST_DEPTH - offset) % HIST_DEPTH;
                        phase = PH_COPY;
                    end
                end
                default:
                begin
                    while (walk <= INNER_N && bits_left > 0)
                    begin
                        walk = take_bit() ? hi_of(0, walk) : lo_of(0, walk);
                        if (walk == 0) walk = ROOT_NODE;
                    end
                    if (walk <= INNER_N)
                    begin
                        st = STAT_NEED;
                        done = 1;
                    end
                    else
                    begin
                        sym = walk - LEAF_FIRST;
                        walk = ROOT_NODE;
                        tree_update(0, sym);
                        if (sym < SYM_TERMINATE)
                        begin
                            hist[wpos] = 8'(sym);
                            wpos = (wpos + 1) % HIST_DEPTH;
                            b = 8'(sym);
                            st = STAT_BYTE;
                            done = 1;
                        end
                        else if (sym == SYM_TERMINATE)
                        begin
                            phase = PH_END;
                            st = STAT_END;
                            done = 1;
                        end
                        else
                        begin
                            t = sym - FIRST_COPY;
                            idx = t / CODES_RANGE;
                            if (idx > LAST_RANGE) idx = LAST_RANGE;
                            crange = idx;
                            crem = t + COPY_LEN_MIN - idx * CODES_RANGE;
                            ext_need = extra_bits(idx);
                            ext_got = 0;
                            ext_val = 0;
                            phase = PH_EXTRA;
                        end
                    end
                end
            endcase
        end
    endtask

    task automatic issue(input logic [1:0] req_op, input logic [15:0] word,
                         output status_t st);
        request_t  rq;
        response_t rs;
        logic [7:0] b;
        b = 8'd0;
        st = STAT_ACK;
        rq.op = req_op;
        rq.word = word;
        requests.push_back(rq);
        if (req_op == OP_START)
            decoder_reset();
        else if (req_op == OP_PUSH)
        begin
            if (bits_left == 0)
            begin
                sreg = word;
                bits_left = 16;
            end
        end
        else if (req_op == OP_PULL)
            decode_pull(b, st);
        rs.byte_val = (st == STAT_BYTE) ? b : 8'd0;
        rs.stat = st;
        rs.last = (st == STAT_END);
        responses.push_back(rs);
    endtask

    function automatic void encode_sym(int sym, int extra);
        int n, p, t, idx;
        bit path[$];
        n = sym + LEAF_FIRST;
        while (n != ROOT_NODE)
        begin
            p = up_of(1, n);
            path.push_front(hi_of(1, p) == n);
            n = p;
        end
        foreach (path[i]) code_bits.push_back(path[i]);
        tree_update(1, sym);
        if (sym < SYM_TERMINATE)
            enc_written++;
        else if (sym > SYM_TERMINATE)
        begin
            t = sym - FIRST_COPY;
            idx = t / CODES_RANGE;
            if (idx > LAST_RANGE) idx = LAST_RANGE;
            enc_written += t + COPY_LEN_MIN - idx * CODES_RANGE;
            for (int i = 0; i < extra_bits(idx); i++) code_bits.push_back((extra >> i) & 1);
        end
    endfunction

    // Copies only reach back into bytes already written in this block.
    function automatic void encode_random(bit long_blk);
        int copy_pct, idx, maxidx, len, lenmax, emax, long_pct;
        bit early;
        early = long_blk && enc_written < 6000;
        copy_pct = early ? 25 : 30;
        long_pct = early ? 2 : 8;
        if (enc_written >= COPY_LEN_MIN && enc_written < WRITE_CAP
            && $urandom_range(0, 99) < copy_pct)
        begin
            maxidx = 0;
            for (int i = 1; i <= LAST_RANGE; i++)
                if (dist_base(i) + COPY_LEN_MIN <= enc_written) maxidx = i;
            idx = $urandom_range(0, maxidx);
            lenmax = enc_written - dist_base(idx);
            if (lenmax > 255) lenmax = 255;
            if ($urandom_range(0, 99) < long_pct)
                len = $urandom_range(COPY_LEN_MIN, lenmax);
            else
                len = $urandom_range(COPY_LEN_MIN, (lenmax < 10) ? lenmax : 10);
            emax = enc_written - dist_base(idx) - len;
            if (emax > (1 << extra_bits(idx)) - 1) emax = (1 << extra_bits(idx)) - 1;
            encode_sym(FIRST_COPY + idx * CODES_RANGE + len - COPY_LEN_MIN,
                       $urandom_range(0, emax));
        end
        else
            encode_sym($urandom_range(0, 255), 0);
    endfunction

    function automatic logic [15:0] next_word(bit long_blk);
        logic [15:0] w;
        while (code_bits.size() < 16)
        begin
            if (plan_sym.size() > 0)
                encode_sym(plan_sym.pop_front(), plan_extra.pop_front());
            else if (syms_left > 0)
            begin
                encode_random(long_blk);
                syms_left--;
            end
            else if (!term_sent)
            begin
                encode_sym(SYM_TERMINATE, 0);
                term_sent = 1;
            end
            else
                code_bits.push_back($urandom_range(0, 1));
        end
        w = 16'd0;
        for (int i = 0; i < 16; i++) w = {w[14:0], code_bits.pop_front()};
        return w;
    endfunction

    task automatic run_block(int nsym, bit long_blk, bit directed);
        status_t st;
        int r;
        blocks++;
        issue(OP_START, 16'($urandom_range(0, 65535)), st);
        tree_reset(1);
        code_bits.delete();
        enc_written = 0;
        syms_left = nsym;
        term_sent = 0;
        if (directed)
        begin
            issue(OP_PULL, 16'hffff, st);
            issue(OP_IGNORED, 16'hffff, st);
            issue(OP_IGNORED, 16'h0000, st);
            plan_sym = '{0, 255, 8'haa, 8'h55, FIRST_COPY, FIRST_COPY + 1, FIRST_COPY + 1};
            plan_extra = '{0, 0, 0, 0, 0, 3, 0};
            issue(OP_PUSH, next_word(0), st);
            issue(OP_PUSH, 16'hffff, st);
            issue(OP_PUSH, 16'h0000, st);
        end
        else if ($urandom_range(0, 1))
            issue(OP_PUSH, next_word(long_blk), st);
        while (phase != PH_END)
        begin
            r = $urandom_range(0, 99);
            if (!long_blk && r < 2)
                return;
            else if (r < 6)
                issue(OP_IGNORED, 16'($urandom_range(0, 65535)), st);
            else if (r < 10 && bits_left > 0)
                issue(OP_PUSH, 16'($urandom_range(0, 65535)), st);
            else
            begin
                issue(OP_PULL, 16'($urandom_range(0, 65535)), st);
                if (st == STAT_NEED)
                begin
                    if ($urandom_range(0, 4) == 0)
                        issue(OP_PULL, 16'($urandom_range(0, 65535)), st);
                    issue(OP_PUSH, next_word(long_blk), st);
                end
            end
        end
        repeat ($urandom_range(directed ? 2 : 0, 2))
            issue(OP_PULL, 16'($urandom_range(0, 65535)), st);
        if (directed)
            issue(OP_PUSH, 16'h5a5a, st);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 150);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        request_t rq;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            op <= 2'd0;
            data_word <= 16'd0;
            in_gap <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (requests.size() > 0)
            begin
                rq = requests.pop_front();
                op <= rq.op;
                data_word <= rq.word;
                in_valid <= 1'b1;
                in_gap <= pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        response_t rs;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (responses.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with none expected: byte %0d status %0d last %0d",
                             $time, out_byte, status, is_last);
                end
                else
                begin
                    rs = responses.pop_front();
                    results_checked++;
                    if (rs.stat == STAT_BYTE) bytes_checked++;
                    if (out_byte !== rs.byte_val)
                    begin
                        errors++;
                        $display("%0t: out_byte expected %0d actual %0d",
                                 $time, rs.byte_val, out_byte);
                    end
                    if (status !== rs.stat)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d", $time, rs.stat, status);
                    end
                    if (is_last !== rs.last)
                    begin
                        errors++;
                        $display("%0t: is_last expected %0d actual %0d",
                                 $time, rs.last, is_last);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 99) < 15) stall_left <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("adaptive_huffman_lz_decompressor: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        decoder_reset();
        run_block(0, 0, 1);
        while (requests.size() < 200)
            run_block($urandom_range(1, 30), 0, 0);
        run_block(230, 1, 0);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (requests.size() == 0 && !in_valid && responses.size() == 0);
        repeat (400) @(posedge clk);
        $display("Checked %0d responses in %0d blocks, %0d of them decoded bytes.",
                 results_checked, blocks, bytes_checked);
        if (errors == 0)
            $display("adaptive_huffman_lz_decompressor: match");
        else
            $display("adaptive_huffman_lz_decompressor: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ahlz_pkg.sv
rtl/ahlz_ram.sv
rtl/adaptive_huffman_lz_decompressor.sv
test/adaptive_huffman_lz_decompressor_test.sv
